[hw/rtl/asit_pkg.sv]
package asit_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_BAD = 2'd1,
    ST_END = 2'd2
  } status_e;

  // Character codes that the scanner recognizes.
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  // Saturation limits of the magnitude for each sign.
  localparam logic [31:0] LIM_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] LIM_NEG = 32'h8000_0000;

  // Default depth of the result queue; at least two.
  localparam int unsigned OUT_DEPTH = 4;

  // One result item.
  typedef struct packed {
    logic signed [31:0] value;
    status_e            status;
    logic               last;
  } result_t;

  // Up to two results that one input item pushes into the queue.
  typedef struct packed {
    logic    vld0;
    logic    vld1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

[hw/rtl/asit_core.sv]
module asit_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    char_in_i,
  input  logic          end_mark_i,
  input  logic          room_i,
  output asit_pkg::push_t push_o
);
  import asit_pkg::*;

  logic        vld_q;
  logic [7:0]  char_q;
  logic        end_q;
  logic        in_num_q, in_num_d;
  logic        neg_q, neg_d;
  logic [31:0] mag_q, mag_d;

  logic        take;
  logic        accept;
  logic        is_ws, is_digit;
  logic [3:0]  digit;
  logic [35:0] prod;
  logic [35:0] lim;
  logic [31:0] sval;

  // The held item is worked on once the queue has room for two results.
  assign take       = vld_q && room_i;
  assign in_stall_o = vld_q && !room_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (take) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= char_in_i;
      end_q  <= end_mark_i;
    end
  end

  // Character classes of the held byte.
  assign is_ws    = (char_q == CHAR_SPACE) || (char_q >= CHAR_TAB && char_q <= CHAR_CR);
  assign is_digit = (char_q >= CHAR_ZERO) && (char_q <= CHAR_NINE);
  assign digit    = 4'(char_q - CHAR_ZERO);

  // Multiply by ten as two shifts and add the new digit.
  assign prod = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) + {32'b0, digit};
  assign lim  = neg_q ? {4'b0, LIM_NEG} : {4'b0, LIM_POS};
  assign sval = neg_q ? (32'd0 - mag_q) : mag_q;

  // Scanner state update and result generation.
  always_comb begin
    in_num_d = in_num_q;
    neg_d    = neg_q;
    mag_d    = mag_q;
    push_o   = '0;
    push_o.r0.status = ST_OK;
    push_o.r1.status = ST_OK;
    if (take) begin
      if (end_q) begin
        push_o.vld0 = 1'b1;
        if (in_num_q) begin
          push_o.r0.value  = $signed(sval);
          push_o.r0.status = ST_OK;
        end else begin
          push_o.r0.status = ST_END;
        end
        in_num_d = 1'b0;
        neg_d    = 1'b0;
        mag_d    = '0;
      end else if (in_num_q && is_digit) begin
        mag_d = (prod > lim) ? lim[31:0] : prod[31:0];
      end else begin
        // A non-digit closes an open number, then starts a new scan.
        if (in_num_q) begin
          push_o.vld0      = 1'b1;
          push_o.r0.value  = $signed(sval);
          push_o.r0.status = ST_OK;
          in_num_d = 1'b0;
          neg_d    = 1'b0;
          mag_d    = '0;
        end
        if (is_ws) begin
          in_num_d = in_num_d;
        end else if (char_q == CHAR_MINUS) begin
          in_num_d = 1'b1;
          neg_d    = 1'b1;
          mag_d    = '0;
        end else if (char_q == CHAR_PLUS) begin
          in_num_d = 1'b1;
          neg_d    = 1'b0;
          mag_d    = '0;
        end else if (is_digit) begin
          in_num_d = 1'b1;
          neg_d    = 1'b0;
          mag_d    = {28'b0, digit};
        end else if (in_num_q) begin
          push_o.vld1      = 1'b1;
          push_o.r1.status = ST_BAD;
        end else begin
          push_o.vld0      = 1'b1;
          push_o.r0.status = ST_BAD;
        end
      end
      // Mark the final result of this item.
      if (push_o.vld1) begin
        push_o.r1.last = 1'b1;
      end else if (push_o.vld0) begin
        push_o.r0.last = 1'b1;
      end
    end
  end

  // Scanner state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_num_q <= 1'b0;
      neg_q    <= 1'b0;
      mag_q    <= '0;
    end else begin
      in_num_q <= in_num_d;
      neg_q    <= neg_d;
      mag_q    <= mag_d;
    end
  end

endmodule

[hw/rtl/asit_fifo.sv]
module asit_fifo #(
  parameter int unsigned Depth = asit_pkg::OUT_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  asit_pkg::push_t   push_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output asit_pkg::result_t head_o
);
  import asit_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);

  result_t         mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, wr_nx, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    inc = (p == LastIdx) ? '0 : p + 1'b1;
  endfunction

  assign room_o      = cnt_q <= CntW'(Depth - 2);
  assign out_valid_o = cnt_q != '0;
  assign head_o      = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign wr_nx       = inc(wr_q);

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i.vld1) begin
      wr_d  = inc(wr_nx);
      cnt_d = cnt_d + CntW'(2);
    end else if (push_i.vld0) begin
      wr_d  = wr_nx;
      cnt_d = cnt_d + CntW'(1);
    end
    if (pop) begin
      rd_d  = inc(rd_q);
      cnt_d = cnt_d - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Result storage; the second result goes to the following slot.
  always_ff @(posedge clk_i) begin
    if (push_i.vld0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.vld1) begin
      mem_q[wr_nx] <= push_i.r1;
    end
  end

endmodule

[hw/rtl/ascii_signed_int_tokenizer.sv]
// Signed decimal integer tokenizer. Takes one text byte per transfer on the
// input channel (or an end mark) and gives 32-bit saturated integers on the
// output channel, with status ok, bad character or end without a number;
// last marks the final result of one input byte, which may cause zero, one
// or two results. A byte enters an input register, is processed by a
// multiply-by-ten-and-add against the scanner state, and its results go
// into a small result queue, so one byte is taken every cycle as long as
// results drain at one per cycle. The first result is offered once the byte
// has passed the input register and been written into the result queue.
// The input stalls only when the queue lacks room for two more results.
module ascii_signed_int_tokenizer #(
  parameter int unsigned OutDepth = asit_pkg::OUT_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_in_i,
  input  logic               end_mark_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o,
  output logic [1:0]         status_o,
  output logic               last_o
);
  import asit_pkg::*;

  push_t   push;
  logic    room;
  result_t head;

  // Scanner with its input register.
  asit_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .char_in_i  (char_in_i),
    .end_mark_i (end_mark_i),
    .room_i     (room),
    .push_o     (push)
  );

  // Result queue toward the output channel.
  asit_fifo #(
    .Depth (OutDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign value_o  = head.value;
  assign status_o = head.status;
  assign last_o   = head.last;

  // A second result never comes without a first one.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push.vld1 |-> push.vld0)
    else $error("second result pushed without a first");

  // Results are only produced when the queue has room for them.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push.vld0 |-> room)
    else $error("result pushed into a full queue");

  // With two results, only the second carries the last mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.vld1 |-> (push.r1.last && !push.r0.last))
    else $error("last mark on the wrong result");

  // An end without a number gives a single zero result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.vld0 && push.r0.status == ST_END) |-> (push.r0.value == 0 && !push.vld1))
    else $error("malformed end-of-data result");

endmodule

[verif/tb_top.sv]
module tb_top;
  import asit_pkg::*;

  localparam int MAX_CYCLES = 400000;
  localparam int HOLD_CYCLES = 150;
  localparam int MAX_GAP = 18;
  localparam int TARGET_ITEMS = 380;

  // Tracks the tokenizer's scanner state and the results it still owes.
  class int_token_board;
    bit            open_num;
    bit            neg_num;
    logic [31:0]   mag;
    result_t       owed[$];
    result_t       step_out[$];
    int            errors;
    int            n_ok;
    int            n_bad;
    int            n_end;
    int            n_sat;

    function new();
      open_num = 1'b0;
      neg_num  = 1'b0;
      mag      = '0;
      errors   = 0;
      n_ok     = 0;
      n_bad    = 0;
      n_end    = 0;
      n_sat    = 0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function int outstanding();
      return owed.size();
    endfunction

    function void add_result(logic signed [31:0] v, status_e s);
      result_t r;
      r.value  = v;
      r.status = s;
      r.last   = 1'b0;
      step_out.push_back(r);
    endfunction

    // Closes the open number and reports it with its sign applied.
    function void close_number();
      add_result(neg_num ? -mag : mag, ST_OK);
      open_num = 1'b0;
      neg_num  = 1'b0;
      mag      = '0;
    endfunction

    // A byte seen while looking for the start of a number.
    function void scan_start(logic [7:0] c);
      if (is_blank(c)) begin
        return;
      end
      if (c == CHAR_MINUS || c == CHAR_PLUS) begin
        open_num = 1'b1;
        neg_num  = (c == CHAR_MINUS);
        mag      = '0;
      end else if (is_digit(c)) begin
        open_num = 1'b1;
        neg_num  = 1'b0;
        mag      = 32'(c - CHAR_ZERO);
      end else begin
        add_result('0, ST_BAD);
      end
    endfunction

    // Works out what one accepted input transfer will produce.
    function void note_input(logic [7:0] c, logic end_mark);
      logic [63:0] grown;
      logic [63:0] limit;
      step_out.delete();
      if (end_mark) begin
        if (open_num) begin
          close_number();
        end else begin
          add_result('0, ST_END);
        end
      end else if (open_num) begin
        if (is_digit(c)) begin
          limit = neg_num ? {32'd0, LIM_NEG} : {32'd0, LIM_POS};
          grown = {32'd0, mag} * 64'd10 + 64'(c - CHAR_ZERO);
          if (grown > limit) begin
            grown = limit;
            n_sat++;
          end
          mag = grown[31:0];
        end else begin
          close_number();
          scan_start(c);
        end
      end else begin
        scan_start(c);
      end
      if (step_out.size() > 0) begin
        step_out[step_out.size() - 1].last = 1'b1;
      end
      foreach (step_out[i]) begin
        owed.push_back(step_out[i]);
      end
    endfunction

    // Compares one output transfer against the oldest owed result.
    function void check_result(logic signed [31:0] v, logic [1:0] s, logic l);
      result_t want;
      if (owed.size() == 0) begin
        $error("unexpected result: value %0d status %0d last %0d", v, s, l);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (v !== want.value) begin
        $error("value: expected %0d, got %0d", want.value, v);
        errors++;
      end
      if (s !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, s);
        errors++;
      end
      if (l !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, l);
        errors++;
      end
      case (want.status)
        ST_OK:   n_ok++;
        ST_BAD:  n_bad++;
        default: n_end++;
      endcase
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         char_in_i;
  logic               end_mark_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] value_o;
  logic [1:0]         status_o;
  logic               last_o;

  int_token_board board;
  bit             quiet;
  bit             rush;
  bit             hold_req;
  int             cycles;
  int             items_sent;

  ascii_signed_int_tokenizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_in_i   (char_in_i),
    .end_mark_i  (end_mark_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  // Free-running clock with a period of two time units.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run-time guard against a hung handshake.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("tb_top: timeout after %0d cycles", cycles);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Mostly short waits, with the full range drawn now and then.
  function automatic int pick_gap();
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, MAX_GAP) : 0;
  endfunction

  function automatic logic [7:0] pick_blank();
    if ($urandom_range(0, 6) == 0) begin
      return CHAR_SPACE;
    end
    return CHAR_TAB + 8'($urandom_range(0, 4));
  endfunction

  // Offers one byte or end mark and waits for its transfer.
  task automatic send_item(input logic [7:0] c, input logic e);
    int gap;
    gap = (quiet || rush) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    char_in_i  = c;
    end_mark_i = e;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_input(c, e);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (board.outstanding() != 0) @(negedge clk_i);
  endtask

  // A whitespace run followed by a number, stray byte or end mark.
  task automatic send_group();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    n = $urandom_range(0, 2);
    repeat (n) send_item(pick_blank(), 1'b0);
    if (kind < 7) begin
      case ($urandom_range(0, 3))
        0:       send_item(CHAR_MINUS, 1'b0);
        1:       send_item(CHAR_PLUS, 1'b0);
        default: ;
      endcase
      if (kind == 6) begin
        n = $urandom_range(0, 1);
      end else if ($urandom_range(0, 6) == 0) begin
        n = $urandom_range(9, 12);
      end else begin
        n = $urandom_range(1, 4);
      end
      repeat (n) send_item(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
      // The number ends on whitespace, an end mark, a sign or any byte.
      case ($urandom_range(0, 5))
        0:       send_item(8'($urandom), 1'b1);
        1:       send_item(($urandom_range(0, 1) != 0) ? CHAR_MINUS : CHAR_PLUS, 1'b0);
        2:       send_item(8'($urandom_range(0, 255)), 1'b0);
        default: send_item(pick_blank(), 1'b0);
      endcase
    end else if (kind < 9) begin
      send_item(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_item(8'($urandom), 1'b1);
    end
  endtask

  // Result side: random stalls, one long hold-off on request.
  initial begin
    int gap;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        gap = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        gap = quiet ? 0 : pick_gap();
      end
      if (gap > 0) begin
        out_stall_i = 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      board.check_result(value_o, status_o, last_o);
      @(negedge clk_i);
    end
  end

  // Reset, directed bytes, then random text with pressure phases.
  initial begin
    int group;
    board      = new();
    quiet      = 1'b0;
    rush       = 1'b0;
    hold_req   = 1'b0;
    cycles     = 0;
    items_sent = 0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    char_in_i  = '0;
    end_mark_i = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // End mark with nothing open; the byte lane is ignored.
    send_item(8'hFF, 1'b1);
    // Lone plus ended by a letter gives zero and then a bad character.
    send_item(CHAR_PLUS, 1'b0);
    send_item("x", 1'b0);
    // Lone minus flushed by an end mark, then a repeated end mark.
    send_item(CHAR_MINUS, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'h00, 1'b1);
    // Bytes above 127 are bad characters.
    send_item(8'h80, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CHAR_SPACE, 1'b0);
    // Negative saturation, closed by a sign that opens the next number.
    send_item(CHAR_MINUS, 1'b0);
    repeat (10) send_item(CHAR_NINE, 1'b0);
    send_item(CHAR_PLUS, 1'b0);
    send_item(CHAR_ZERO, 1'b0);
    send_item(CHAR_CR, 1'b0);
    // A digit still open when the data ends.
    send_item(CHAR_NINE, 1'b0);
    send_item(8'h00, 1'b1);
    wait_drained();

    group = 0;
    while (items_sent < TARGET_ITEMS) begin
      group++;
      quiet = (group >= 20 && group < 35);
      if (group == 50) begin
        hold_req = 1'b1;
      end
      rush = (group >= 50 && group < 65);
      if (group == 70) begin
        wait_drained();
      end
      send_group();
    end
    rush = 1'b0;
    quiet = 1'b0;

    // Let the last results drain, plus the pipeline depth.
    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("tb_top: %0d items sent over %0d cycles, %0d saturations predicted",
             items_sent, cycles, board.n_sat);
    $display("tb_top: results checked: %0d numbers, %0d bad characters, %0d empty ends",
             board.n_ok, board.n_bad, board.n_end);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
